/* sv/cfgm_pkg.sv */
`timescale 1ns / 1ps
package cfgm_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int BUS_W     = 28;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 12;
	localparam int FRAME_W   = 32;
	localparam int DIV_STEPS = GAIN_W;
	localparam int PROD_W    = GAIN_W + FRAME_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CLIP_GAIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMELINE_START  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LENGTH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_OFFSET   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LENGTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_LENGTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_LENGTH = 3'd6;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

	// payload riding alongside the divider stages
	typedef struct packed {
		logic                       stereo;
		logic                       hit;
		logic signed [SAMPLE_W-1:0] src_l;
		logic signed [SAMPLE_W-1:0] src_r;
		logic signed [BUS_W-1:0]    bus_l;
		logic signed [BUS_W-1:0]    bus_r;
		logic                       fo_act;
		logic [FRAME_W-1:0]         rem;
	} side_t;

endpackage

/* sv/cfgm_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Requires dividend[47:16] < divisor so the quotient fits 16 bits.
module cfgm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic [cfgm_pkg::PROD_W-1:0]       dividend,
	input  logic [cfgm_pkg::FRAME_W-1:0]      divisor,
	input  cfgm_pkg::side_t                   side_in,
	output logic                              out_vld,
	output logic [cfgm_pkg::GAIN_W-1:0]       quotient,
	output cfgm_pkg::side_t                   side_out
);

	localparam int N = cfgm_pkg::DIV_STEPS;
	localparam int W = cfgm_pkg::FRAME_W;

	logic                  vld_s  [0:N-1];
	logic [W-1:0]          rem_s  [0:N-1];
	logic [N-1:0]          lo_s   [0:N-1];
	logic [W-1:0]          dvs_s  [0:N-1];
	cfgm_pkg::side_t       side_s [0:N-1];

	wire                   vld_p  [0:N-1];
	wire [W-1:0]           rem_p  [0:N-1];
	wire [N-1:0]           lo_p   [0:N-1];
	wire [W-1:0]           dvs_p  [0:N-1];
	wire cfgm_pkg::side_t  side_p [0:N-1];

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_stage
			logic [W:0] shifted;
			logic [W:0] diff;
			logic       qbit;

			if (i == 0) begin : g_first
				assign vld_p[i]  = in_vld;
				assign rem_p[i]  = dividend[cfgm_pkg::PROD_W-1:N];
				assign lo_p[i]   = dividend[N-1:0];
				assign dvs_p[i]  = divisor;
				assign side_p[i] = side_in;
			end else begin : g_rest
				assign vld_p[i]  = vld_s[i-1];
				assign rem_p[i]  = rem_s[i-1];
				assign lo_p[i]   = lo_s[i-1];
				assign dvs_p[i]  = dvs_s[i-1];
				assign side_p[i] = side_s[i-1];
			end

			always_comb begin
				shifted = {rem_p[i], lo_p[i][N-1]};
				diff    = shifted - {1'b0, dvs_p[i]};
				qbit    = (shifted >= {1'b0, dvs_p[i]});
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en) begin
					vld_s[i] <= vld_p[i];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i]  <= qbit ? diff[W-1:0] : shifted[W-1:0];
					lo_s[i]   <= {lo_p[i][N-2:0], qbit};
					dvs_s[i]  <= dvs_p[i];
					side_s[i] <= side_p[i];
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[N-1];
	assign quotient = lo_s[N-1];
	assign side_out = side_s[N-1];

endmodule

/* sv/clip_fade_gain_mixer.sv */
`timescale 1ns / 1ps
// Clip mixer: each input transaction is one timeline frame (frame number,
// source samples, current bus values); each output transaction is the bus
// after this clip's contribution, with contributed set when the clip added
// to the frame. A frame inside the clip and inside the media gets clip_gain
// times the fade-in ramp (n+1)/fade_in_length and the fade-out ramp
// remaining/fade_out_length, truncated at each step, times the sample
// (floor), added to the bus with saturation; mono sources feed both sides.
// Throughput is one transaction per clock while the output is not stalled. An
// accepted input passes three front stages (frame offset, window
// tests, gain product), two 16-stage one-bit-per-stage dividers (one per
// fade ramp), a ramp product stage, a sample product stage and the
// shift/saturate stage. The whole pipeline holds when out_ready is low
// with out_valid set, so in_ready is combinational: !out_valid || out_ready.
// Registers are written through cfg_we/cfg_index/cfg_data and should only
// change while the pipeline is empty.
module clip_fade_gain_mixer (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// configuration
	input  logic                                     cfg_we,
	input  logic [cfgm_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [cfgm_pkg::FRAME_W-1:0]             cfg_data,
	// input channel
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [cfgm_pkg::FRAME_W-1:0]             timeline_frame,
	input  logic signed [cfgm_pkg::SAMPLE_W-1:0]     source_left,
	input  logic signed [cfgm_pkg::SAMPLE_W-1:0]     source_right,
	input  logic                                     stereo_source,
	input  logic signed [cfgm_pkg::BUS_W-1:0]        bus_left,
	input  logic signed [cfgm_pkg::BUS_W-1:0]        bus_right,
	// output channel
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [cfgm_pkg::BUS_W-1:0]        mix_left,
	output logic signed [cfgm_pkg::BUS_W-1:0]        mix_right,
	output logic                                     contributed
);

	localparam int FW = cfgm_pkg::FRAME_W;
	localparam int GW = cfgm_pkg::GAIN_W;
	localparam int PW = cfgm_pkg::PROD_W;
	localparam int SW = cfgm_pkg::SAMPLE_W;
	localparam int BW = cfgm_pkg::BUS_W;
	localparam int MW = SW + GW + 1;            // sample x (gain as signed)
	localparam int AW = MW - cfgm_pkg::GAIN_FRAC; // contribution width

	// ---------------- configuration registers ----------------
	logic [GW-1:0] gain_q;
	logic [FW-1:0] tl_start_q, clip_len_q, src_off_q, src_len_q, fade_in_q, fade_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= cfgm_pkg::GAIN_RESET;
			tl_start_q <= '0;
			clip_len_q <= '0;
			src_off_q  <= '0;
			src_len_q  <= '0;
			fade_in_q  <= '0;
			fade_out_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cfgm_pkg::REG_CLIP_GAIN:       gain_q     <= cfg_data[GW-1:0];
				cfgm_pkg::REG_TIMELINE_START:  tl_start_q <= cfg_data;
				cfgm_pkg::REG_CLIP_LENGTH:     clip_len_q <= cfg_data;
				cfgm_pkg::REG_SOURCE_OFFSET:   src_off_q  <= cfg_data;
				cfgm_pkg::REG_SOURCE_LENGTH:   src_len_q  <= cfg_data;
				cfgm_pkg::REG_FADE_IN_LENGTH:  fade_in_q  <= cfg_data;
				cfgm_pkg::REG_FADE_OUT_LENGTH: fade_out_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: every stage moves unless the output is stuck
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: clip frame ----------------
	logic          vld_s1, ge_s1;
	logic [FW-1:0] n_s1;
	logic          stereo_s1;
	logic signed [SW-1:0] src_l_s1, src_r_s1;
	logic signed [BW-1:0] bus_l_s1, bus_r_s1;
	logic [FW:0]   n_diff;

	assign n_diff = {1'b0, timeline_frame} - {1'b0, tl_start_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1      <= n_diff[FW-1:0];
			ge_s1     <= !n_diff[FW];   // no borrow: frame >= start
			stereo_s1 <= stereo_source;
			src_l_s1  <= source_left;
			src_r_s1  <= source_right;
			bus_l_s1  <= bus_left;
			bus_r_s1  <= bus_right;
		end
	end

	// ---------------- stage 2: window tests and ramp numerators ----------------
	logic          vld_s2, fi_act_s2;
	logic [FW-1:0] kin_s2;
	cfgm_pkg::side_t side_s2;
	logic [FW:0]   media_pos, fo_end, kin_sum;
	logic          hit_c, fi_c, fo_c;

	always_comb begin
		media_pos = {1'b0, src_off_q} + {1'b0, n_s1};
		fo_end    = {1'b0, n_s1} + {1'b0, fade_out_q};
		kin_sum   = {1'b0, n_s1} + {{FW{1'b0}}, 1'b1};
		hit_c     = ge_s1 && (n_s1 < clip_len_q) && (media_pos < {1'b0, src_len_q});
		fi_c      = (fade_in_q != '0) && (n_s1 < fade_in_q);
		fo_c      = (fade_out_q != '0) && (fo_end >= {1'b0, clip_len_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fi_act_s2      <= fi_c;
			kin_s2         <= kin_sum[FW-1:0];
			side_s2.stereo <= stereo_s1;
			side_s2.hit    <= hit_c;
			side_s2.src_l  <= src_l_s1;
			side_s2.src_r  <= src_r_s1;
			side_s2.bus_l  <= bus_l_s1;
			side_s2.bus_r  <= bus_r_s1;
			side_s2.fo_act <= fo_c;
			side_s2.rem    <= clip_len_q - n_s1;
		end
	end

	// ---------------- stage 3: gain x fade-in numerator ----------------
	// an inactive ramp divides g*1 by 1
	logic          vld_s3;
	logic [PW-1:0] prod_s3;
	logic [FW-1:0] dvs_s3;
	cfgm_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PW'(gain_q) * PW'(fi_act_s2 ? kin_s2 : FW'(1));
			dvs_s3  <= fi_act_s2 ? fade_in_q : FW'(1);
			side_s3 <= side_s2;
		end
	end

	// ---------------- fade-in divider ----------------
	logic          d1_vld;
	logic [GW-1:0] q1;
	cfgm_pkg::side_t d1_side;

	cfgm_div u_div_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.dividend (prod_s3),
		.divisor  (dvs_s3),
		.side_in  (side_s3),
		.out_vld  (d1_vld),
		.quotient (q1),
		.side_out (d1_side)
	);

	// ---------------- stage 4: gain x fade-out numerator ----------------
	logic          vld_s4;
	logic [PW-1:0] prod_s4;
	logic [FW-1:0] dvs_s4;
	cfgm_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= d1_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= PW'(q1) * PW'(d1_side.fo_act ? d1_side.rem : FW'(1));
			dvs_s4  <= d1_side.fo_act ? fade_out_q : FW'(1);
			side_s4 <= d1_side;
		end
	end

	// ---------------- fade-out divider ----------------
	logic          d2_vld;
	logic [GW-1:0] q2;
	cfgm_pkg::side_t d2_side;

	cfgm_div u_div_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.dividend (prod_s4),
		.divisor  (dvs_s4),
		.side_in  (side_s4),
		.out_vld  (d2_vld),
		.quotient (q2),
		.side_out (d2_side)
	);

	// ---------------- stage 5: sample x gain ----------------
	logic                 vld_s5, hit_s5;
	logic signed [MW-1:0] pl_s5, pr_s5;
	logic signed [BW-1:0] bus_l_s5, bus_r_s5;
	logic signed [GW:0]   g_sgn;

	assign g_sgn = $signed({1'b0, q2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= d2_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s5    <= MW'(d2_side.src_l) * MW'(g_sgn);
			// mono: left sample feeds the right side too
			pr_s5    <= MW'(d2_side.stereo ? d2_side.src_r : d2_side.src_l) * MW'(g_sgn);
			bus_l_s5 <= d2_side.bus_l;
			bus_r_s5 <= d2_side.bus_r;
			hit_s5   <= d2_side.hit;
		end
	end

	// ---------------- stage 6: floor shift, add, saturate ----------------
	logic signed [AW-1:0] add_l, add_r;
	logic signed [AW:0]   sum_l, sum_r;
	logic signed [BW-1:0] sat_l, sat_r;

	function automatic logic signed [BW-1:0] sat_bus(input logic signed [AW:0] v);
		logic signed [AW:0] hi;
		logic signed [AW:0] lo;
		hi = (AW+1)'({1'b0, {(BW-1){1'b1}}});
		lo = -hi - (AW+1)'(1);
		if (v > hi)      sat_bus = hi[BW-1:0];
		else if (v < lo) sat_bus = lo[BW-1:0];
		else             sat_bus = v[BW-1:0];
	endfunction

	always_comb begin
		add_l = pl_s5[MW-1:cfgm_pkg::GAIN_FRAC];   // arithmetic floor
		add_r = pr_s5[MW-1:cfgm_pkg::GAIN_FRAC];
		sum_l = (AW+1)'(bus_l_s5) + (AW+1)'(add_l);
		sum_r = (AW+1)'(bus_r_s5) + (AW+1)'(add_r);
		sat_l = sat_bus(sum_l);
		sat_r = sat_bus(sum_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mix_left    <= hit_s5 ? sat_l : bus_l_s5;
			mix_right   <= hit_s5 ? sat_r : bus_r_s5;
			contributed <= hit_s5;
		end
	end

endmodule

/* sv/cfgm_checker.sv */
`timescale 1ns / 1ps
module cfgm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [cfgm_pkg::BUS_W-1:0]    mix_left,
	input logic [cfgm_pkg::BUS_W-1:0]    mix_right,
	input logic                          contributed
);

	// pipeline moves whenever the output slot is free or drained
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not track output slot");

	// in the cycle after reset is seen, the output is empty
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(mix_left) && $stable(mix_right) && $stable(contributed))
		else $error("stalled output changed");

endmodule

bind clip_fade_gain_mixer cfgm_checker u_cfgm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.mix_left    (mix_left),
	.mix_right   (mix_right),
	.contributed (contributed)
);

/* verif/clip_fade_gain_mixer_tb.sv */
`timescale 1ns / 1ps
module clip_fade_gain_mixer_tb;

	localparam int PIPE_LAT  = 37;
	localparam int CYCLE_MAX = 400000;
	localparam int N_RANDOM  = 650;

	localparam int IDX_W = cfgm_pkg::CFG_IDX_W;
	localparam int FW    = cfgm_pkg::FRAME_W;
	localparam int SW    = cfgm_pkg::SAMPLE_W;
	localparam int BW    = cfgm_pkg::BUS_W;
	localparam int GW    = cfgm_pkg::GAIN_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [FW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FW-1:0] timeline_frame = '0;
	logic signed [SW-1:0] source_left = '0;
	logic signed [SW-1:0] source_right = '0;
	logic stereo_source = 1'b0;
	logic signed [BW-1:0] bus_left = '0;
	logic signed [BW-1:0] bus_right = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [BW-1:0] mix_left;
	logic signed [BW-1:0] mix_right;
	logic contributed;

	clip_fade_gain_mixer i_dut (.*);

	always #5 clk = ~clk;

	// one frame transaction and the bus result it should produce
	typedef struct {
		logic [FW-1:0]        frame;
		logic signed [SW-1:0] src_l;
		logic signed [SW-1:0] src_r;
		logic                 stereo;
		logic signed [BW-1:0] bus_l;
		logic signed [BW-1:0] bus_r;
	} frame_t;

	typedef struct {
		logic signed [BW-1:0] mix_l;
		logic signed [BW-1:0] mix_r;
		logic                 hit;
	} mix_t;

	// shadow copy of the clip registers
	logic [GW-1:0] sh_gain;
	logic [FW-1:0] sh_start, sh_len, sh_offs, sh_srclen, sh_fin, sh_fout;

	mix_t pending_mix[$];
	int   n_errors = 0;
	int   n_checked = 0;
	int   n_hits = 0;
	int   cycle_cnt = 0;

	function automatic logic signed [BW-1:0] sat_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > 134217727) s = 134217727;
		if (s < -134217728) s = -134217728;
		return s[BW-1:0];
	endfunction

	// floor of p / 4096, correct for negative products
	function automatic longint gain_scale(longint p);
		return p >>> cfgm_pkg::GAIN_FRAC;
	endfunction

	function automatic mix_t mix_frame(frame_t f);
		mix_t m;
		longint unsigned fr, n, g;
		longint add_l, add_r;
		m.mix_l = f.bus_l;
		m.mix_r = f.bus_r;
		m.hit   = 1'b0;
		fr = f.frame;
		if (fr >= sh_start && fr < longint'(sh_start) + longint'(sh_len)) begin
			n = fr - sh_start;
			if (longint'(sh_offs) + n < sh_srclen) begin
				g = sh_gain;
				if (sh_fin != 0 && n < sh_fin)
					g = (g * (n + 1)) / sh_fin;
				if (sh_fout != 0 && n + sh_fout >= sh_len)
					g = (g * (sh_len - n)) / sh_fout;
				add_l = gain_scale(longint'(f.src_l) * longint'(g));
				add_r = f.stereo ? gain_scale(longint'(f.src_r) * longint'(g)) : add_l;
				m.mix_l = sat_add(f.bus_l, add_l);
				m.mix_r = sat_add(f.bus_r, add_r);
				m.hit   = 1'b1;
			end
		end
		return m;
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [FW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cfgm_pkg::REG_CLIP_GAIN:       sh_gain   = val[GW-1:0];
			cfgm_pkg::REG_TIMELINE_START:  sh_start  = val;
			cfgm_pkg::REG_CLIP_LENGTH:     sh_len    = val;
			cfgm_pkg::REG_SOURCE_OFFSET:   sh_offs   = val;
			cfgm_pkg::REG_SOURCE_LENGTH:   sh_srclen = val;
			cfgm_pkg::REG_FADE_IN_LENGTH:  sh_fin    = val;
			cfgm_pkg::REG_FADE_OUT_LENGTH: sh_fout   = val;
			default: ;
		endcase
	endtask

	task automatic load_clip(logic [GW-1:0] g, logic [FW-1:0] st, logic [FW-1:0] ln,
		logic [FW-1:0] of, logic [FW-1:0] sl, logic [FW-1:0] fi,
		logic [FW-1:0] fo);
		write_reg(cfgm_pkg::REG_CLIP_GAIN, {16'd0, g});
		write_reg(cfgm_pkg::REG_TIMELINE_START, st);
		write_reg(cfgm_pkg::REG_CLIP_LENGTH, ln);
		write_reg(cfgm_pkg::REG_SOURCE_OFFSET, of);
		write_reg(cfgm_pkg::REG_SOURCE_LENGTH, sl);
		write_reg(cfgm_pkg::REG_FADE_IN_LENGTH, fi);
		write_reg(cfgm_pkg::REG_FADE_OUT_LENGTH, fo);
	endtask

	// stop sending and wait out the pipeline between configuration phases
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_mix.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	// drive one transaction, hold until accepted; called at a falling edge
	task automatic send_frame(frame_t f);
		timeline_frame <= f.frame;
		source_left    <= f.src_l;
		source_right   <= f.src_r;
		stereo_source  <= f.stereo;
		bus_left       <= f.bus_l;
		bus_right      <= f.bus_r;
		in_valid       <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_mix.push_back(mix_frame(f));
		@(negedge clk);
	endtask

	// random gap after a burst; valid drops only when a gap follows
	int burst_left = 0;
	task automatic send_paced(frame_t f);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		send_frame(f);
	endtask

	function automatic frame_t rand_frame(logic [FW-1:0] fr);
		frame_t f;
		f.frame  = fr;
		f.src_l  = SW'($urandom);
		f.src_r  = SW'($urandom);
		f.stereo = 1'($urandom_range(0, 1));
		f.bus_l  = BW'($urandom);
		f.bus_r  = BW'($urandom);
		// lean on full-scale values now and then to hit saturation
		if ($urandom_range(0, 7) == 0) f.bus_l = $urandom_range(0, 1) ? 28'h7ffffff : 28'h8000000;
		if ($urandom_range(0, 7) == 0) f.src_l = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
		return f;
	endfunction

	// receiver: alternates no-stall stretches with random stall patterns
	initial begin
		int mode_left, mode;
		mode_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 120);
				mode = $urandom_range(0, 2);
			end
			mode_left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 1) != 0);
			endcase
		end
	end

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		mix_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_mix.size() == 0) begin
				$display("%0t: unexpected output mix_l=%0d mix_r=%0d contributed=%0b",
					$time, mix_left, mix_right, contributed);
				n_errors++;
			end else begin
				e = pending_mix.pop_front();
				n_checked++;
				if (contributed) n_hits++;
				if (mix_left !== e.mix_l) begin
					$display("%0t: mix_left expected %0d actual %0d", $time, e.mix_l, mix_left);
					n_errors++;
				end
				if (mix_right !== e.mix_r) begin
					$display("%0t: mix_right expected %0d actual %0d", $time, e.mix_r, mix_right);
					n_errors++;
				end
				if (contributed !== e.hit) begin
					$display("%0t: contributed expected %0b actual %0b", $time, e.hit, contributed);
					n_errors++;
				end
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_MAX) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, pending_mix.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// directed rows: frame, samples, bus; expected mix typed in where obvious
	typedef struct {
		logic [FW-1:0]        frame;
		logic signed [SW-1:0] src_l;
		logic signed [SW-1:0] src_r;
		logic                 stereo;
		logic signed [BW-1:0] bus_l;
		logic signed [BW-1:0] bus_r;
		logic                 known;
		logic signed [BW-1:0] exp_l;
		logic signed [BW-1:0] exp_r;
		logic                 exp_hit;
	} row_t;

	row_t rows_reset[20];
	row_t rows_clip[20];

	// typed-in expectations only hold for the setup the table was written for
	task automatic run_rows(input row_t r[20], input int cnt, input bit chk);
		frame_t f;
		mix_t m;
		for (int i = 0; i < cnt; i++) begin
			f = '{r[i].frame, r[i].src_l, r[i].src_r, r[i].stereo, r[i].bus_l, r[i].bus_r};
			if (chk && r[i].known) begin
				m = mix_frame(f);
				if (m.mix_l !== r[i].exp_l || m.mix_r !== r[i].exp_r || m.hit !== r[i].exp_hit)
				begin
					$display("%0t: row %0d expected %0d/%0d/%0b actual %0d/%0d/%0b",
						$time, i, r[i].exp_l, r[i].exp_r, r[i].exp_hit,
						m.mix_l, m.mix_r, m.hit);
					n_errors++;
				end
			end
			send_paced(f);
		end
	endtask

	initial begin
		frame_t f;
		logic [FW-1:0] fr;
		int lens[4];
		sh_gain = cfgm_pkg::GAIN_RESET;
		{sh_start, sh_len, sh_offs, sh_srclen, sh_fin, sh_fout} = '0;

		// after reset the clip is disabled: pure pass-through
		rows_reset[0] = '{32'd0, 24'h7fffff, 24'h7fffff, 1, 28'h7ffffff, 28'h8000000, 1,
			28'h7ffffff, 28'h8000000, 0};
		rows_reset[1] = '{32'hffffffff, 24'h800000, 24'h1, 0, 28'd5, -28'sd5, 1, 28'd5,
			-28'sd5, 0};
		rows_reset[2] = '{32'd1, 24'h0, 24'h0, 1, 28'h0, 28'h0, 1, 28'h0, 28'h0, 0};
		rows_reset[3] = '{32'h80000000, 24'h123456, 24'hfedcba, 1, 28'h1234567, 28'h7654321, 1,
			28'h1234567, 28'h7654321, 0};

		// clip at 100..109, media frames 0..7 usable, fades 3 in and 4 out
		rows_clip[0]  = '{32'd99, 24'h7fffff, 24'h7fffff, 1, 28'd7, 28'd9, 1, 28'd7, 28'd9, 0};
		rows_clip[1]  = '{32'd100, 24'h7fffff, 24'h800000, 1, 28'd0, 28'd0, 0, 0, 0, 0};
		rows_clip[2]  = '{32'd101, 24'h800000, 24'h7fffff, 0, 28'd0, 28'd0, 0, 0, 0, 0};
		rows_clip[3]  = '{32'd102, 24'h7fffff, 24'h0, 1, 28'h7ffffff, 28'h8000000, 0, 0, 0, 0};
		rows_clip[4]  = '{32'd103, 24'h800000, 24'h800000, 1, 28'h8000000, 28'h8000000, 0, 0, 0,
			0};
		rows_clip[5]  = '{32'd104, -24'sd1, 24'd1, 1, 28'd0, 28'd0, 0, 0, 0, 0};
		rows_clip[6]  = '{32'd105, 24'd4095, -24'sd4095, 0, 28'd3, 28'd3, 0, 0, 0, 0};
		rows_clip[7]  = '{32'd106, 24'h7fffff, 24'h7fffff, 1, 28'd0, 28'd0, 0, 0, 0, 0};
		rows_clip[8]  = '{32'd107, 24'h7fffff, 24'h7fffff, 1, 28'd0, 28'd0, 0, 0, 0, 0};
		rows_clip[9]  = '{32'd108, 24'h7fffff, 24'h7fffff, 1, 28'd11, 28'd12, 1, 28'd11, 28'd12,
			0};
		rows_clip[10] = '{32'd110, 24'h7fffff, 24'h7fffff, 1, 28'd1, 28'd2, 1, 28'd1, 28'd2, 0};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_rows(rows_reset, 4, 1'b1);
		drain_pipe();
		load_clip(16'hffff, 32'd100, 32'd10, 32'd0, 32'd8, 32'd3, 32'd4);
		run_rows(rows_clip, 11, 1'b1);
		drain_pipe();
		// unity gain without fades; mono and stereo at full scale
		load_clip(cfgm_pkg::GAIN_RESET, 32'd0, 32'hffffffff, 32'd0, 32'hffffffff, 32'd0, 32'd0);
		run_rows(rows_clip, 11, 1'b0);
		drain_pipe();
		// clip ending at the top of the frame range, offset past media end
		load_clip(16'd0, 32'hfffffff0, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff);
		for (int i = 0; i < 4; i++) send_paced(rand_frame(32'hfffffff0 + i * 5));
		drain_pipe();

		// random phases: small clips with random registers, frames around the clip
		lens = '{1, 3, 16, 300};
		for (int ph = 0; ph < 13; ph++) begin
			logic [FW-1:0] st, ln;
			drain_pipe();
			st = (ph % 4 == 3) ? $urandom : $urandom_range(0, 1000);
			ln = lens[$urandom_range(0, 3)] + $urandom_range(0, 20);
			load_clip(GW'($urandom), st, ln, $urandom_range(0, 40), $urandom_range(0, 400),
				$urandom_range(0, 1) ? 0 : $urandom_range(1, ln + 5),
				$urandom_range(0, 1) ? 0 : $urandom_range(1, ln + 5));
			for (int k = 0; k < N_RANDOM / 13; k++) begin
				if ($urandom_range(0, 9) == 0) fr = $urandom;
				else fr = st + $urandom_range(0, ln + 8) - 4;
				send_paced(rand_frame(fr));
				// once per phase hold off until everything in flight is out
				if (k == 20) begin
					in_valid <= 1'b0;
					while (pending_mix.size() != 0) @(negedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_mix.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 10) @(negedge clk);
		$display("Checked %0d mixed frames (%0d with clip contribution) over 16 clip setups,",
			n_checked, n_hits);
		$display("covering fades, mono/stereo, saturation and out-of-range frames.");
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* sim.f */
sv/cfgm_pkg.sv
sv/cfgm_div.sv
sv/clip_fade_gain_mixer.sv
sv/cfgm_checker.sv
verif/clip_fade_gain_mixer_tb.sv
